// ===== rtl/bpsc_pkg.sv =====
// ----------------------------------------------------------------------------
// bpsc_pkg
// Shared types and codes for the byte permutation stream cipher.
// ----------------------------------------------------------------------------
package bpsc_pkg;

   localparam int unsigned BYTE_W    = 8;
   localparam int unsigned TBL_DEPTH = 256;
   localparam int unsigned GEN_W     = 64;
   localparam int unsigned CSR_IDX_W = 2;

   // item commands
   localparam logic CMD_START = 1'b0;
   localparam logic CMD_DATA  = 1'b1;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_LOW  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_HIGH = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 2'd2;

   // generator multiplier is 2^107 - 1: high word takes lo << (107 - 64)
   localparam int unsigned GEN_SHIFT = 43;

   // control from the sequencer to the permutation tables
   typedef struct packed {
      logic              wr_en;    // P[wr_addr] = wr_data, Q[wr_data] = wr_addr
      logic [BYTE_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
   } tbl_ctl_type;

endpackage

// ===== rtl/bpsc_tables.sv =====
// ----------------------------------------------------------------------------
// bpsc_tables
// Forward permutation P and inverse Q. Contents come from the sequencer's
// clearing pass (P[i] = i, Q[i] = i) and later swap writes.
// ----------------------------------------------------------------------------
module bpsc_tables (
   input  logic                            clock,
   input  bpsc_pkg::tbl_ctl_type           ctl,
   input  logic [bpsc_pkg::BYTE_W-1:0]     p_raddr_a,
   input  logic [bpsc_pkg::BYTE_W-1:0]     p_raddr_b,
   input  logic [bpsc_pkg::BYTE_W-1:0]     q_raddr,
   output logic [bpsc_pkg::BYTE_W-1:0]     p_rdata_a,
   output logic [bpsc_pkg::BYTE_W-1:0]     p_rdata_b,
   output logic [bpsc_pkg::BYTE_W-1:0]     q_rdata
);

   logic [bpsc_pkg::BYTE_W-1:0] p_mem [bpsc_pkg::TBL_DEPTH];
   logic [bpsc_pkg::BYTE_W-1:0] q_mem [bpsc_pkg::TBL_DEPTH];

   logic [bpsc_pkg::BYTE_W-1:0] p_rd_a_ff, p_rd_b_ff, q_rd_ff;

   // storage, one write each
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         p_mem[ctl.wr_addr] <= ctl.wr_data;
         q_mem[ctl.wr_data] <= ctl.wr_addr;
      end
   end

   // registered reads
   always_ff @(posedge clock) begin
      p_rd_a_ff <= p_mem[p_raddr_a];
      p_rd_b_ff <= p_mem[p_raddr_b];
      q_rd_ff   <= q_mem[q_raddr];
   end

   assign p_rdata_a = p_rd_a_ff;
   assign p_rdata_b = p_rd_b_ff;
   assign q_rdata   = q_rd_ff;

endmodule

// ===== rtl/byte_permutation_stream_cipher.sv =====
// ----------------------------------------------------------------------------
// byte_permutation_stream_cipher
// Byte stream cipher over a key-evolving 256-entry permutation and its inverse.
// ----------------------------------------------------------------------------
//  channel   direction  handshake            payload
//  req_      in         req_valid/req_stall  req_command, req_data_byte
//  rsp_      out        rsp_valid/rsp_stall  rsp_out_byte
//  csr_      in         csr_valid/csr_ready  csr_index, csr_wdata
//
//  Start item: after accept, a clearing pass (identity into both tables), then
//  256 swaps, each with two passes of the shared 64-bit subtractor and two
//  table writes.
//  Data item: one swap; its two subtractor passes and two table writes set the
//  pace, and no new item is taken until the result goes to the output register.
//  Reset: the same clearing pass runs with req_stall high; generator and key
//  registers zero.
//  A stalled result holds in the output register; the sequencer waits in its
//  last state until that register is free. csr_ready is always high.
// ----------------------------------------------------------------------------
module byte_permutation_stream_cipher (
   input  logic                                clock,
   input  logic                                reset,
   // item input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_command,
   input  logic [bpsc_pkg::BYTE_W-1:0]         req_data_byte,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [bpsc_pkg::BYTE_W-1:0]         rsp_out_byte,
   // register writes
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bpsc_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [bpsc_pkg::GEN_W-1:0]          csr_wdata
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INIT,     // clearing pass after reset, then idle
      ST_CLEAR,    // clearing pass of a start item, then the shuffle
      ST_GEN_HI,   // high word of the generator step; lookup data lands
      ST_GEN_LO,   // low word; key index ready, issue the swap reads
      ST_WR_A,     // P[a] = P[b]
      ST_WR_B,     // P[b] = old P[a]
      ST_FINISH    // hand the result to the output register
   } state_type;

   localparam int unsigned BW = bpsc_pkg::BYTE_W;
   localparam int unsigned GW = bpsc_pkg::GEN_W;

   state_type     state_ff, state_in;
   logic          is_data_ff, is_data_in;
   logic [BW-1:0] byte_ff, byte_in;
   logic [BW-1:0] idx_ff, idx_in;
   logic [GW-1:0] gen_lo_ff, gen_lo_in;
   logic [GW-1:0] gen_hi_ff, gen_hi_in;
   logic [GW-1:0] key_low_ff, key_low_in;
   logic [GW-1:0] key_high_ff, key_high_in;
   logic          decrypt_ff, decrypt_in;
   logic [BW-1:0] plain_ff, plain_in;
   logic [BW-1:0] result_ff, result_in;
   logic [BW-1:0] swap_a_ff, swap_a_in;
   logic [BW-1:0] swap_b_ff, swap_b_in;
   logic [BW-1:0] swap_ta_ff, swap_ta_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [BW-1:0] rsp_byte_ff, rsp_byte_in;

   // shared subtractor: diff = op_a - op_b - borrow_in
   logic [GW-1:0] sub_a, sub_b, sub_diff;
   logic          sub_bin;

   logic          req_take;
   logic          csr_take;
   logic [BW-1:0] key_idx;
   logic [BW-1:0] swap_a_sel;

   bpsc_pkg::tbl_ctl_type tbl_ctl;
   logic [BW-1:0] p_ra, p_rb, q_ra;
   logic [BW-1:0] p_rd_a, p_rd_b, q_rd;

   assign req_stall = (state_ff != ST_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign csr_ready = 1'b1;
   assign csr_take  = csr_valid && csr_ready;

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_byte = rsp_byte_ff;

   assign sub_diff = sub_a - sub_b - GW'(sub_bin);

   // key index from the freshly stepped high word
   assign key_idx    = gen_hi_ff[GW-1 -: BW] ^ gen_hi_ff[GW-BW-1 -: BW];
   assign swap_a_sel = is_data_ff ? plain_ff : idx_ff;

   bpsc_tables u_tables (
      .clock     (clock),
      .ctl       (tbl_ctl),
      .p_raddr_a (p_ra),
      .p_raddr_b (p_rb),
      .q_raddr   (q_ra),
      .p_rdata_a (p_rd_a),
      .p_rdata_b (p_rd_b),
      .q_rdata   (q_rd)
   );

   always_comb begin
      state_in     = state_ff;
      is_data_in   = is_data_ff;
      byte_in      = byte_ff;
      idx_in       = idx_ff;
      gen_lo_in    = gen_lo_ff;
      gen_hi_in    = gen_hi_ff;
      key_low_in   = key_low_ff;
      key_high_in  = key_high_ff;
      decrypt_in   = decrypt_ff;
      plain_in     = plain_ff;
      result_in    = result_ff;
      swap_a_in    = swap_a_ff;
      swap_b_in    = swap_b_ff;
      swap_ta_in   = swap_ta_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      sub_a   = {gen_lo_ff[GW-1-bpsc_pkg::GEN_SHIFT:0], {bpsc_pkg::GEN_SHIFT{1'b0}}};
      sub_b   = gen_hi_ff;
      sub_bin = |gen_lo_ff;

      tbl_ctl.wr_en   = 1'b0;
      tbl_ctl.wr_addr = swap_a_ff;
      tbl_ctl.wr_data = p_rd_b;
      p_ra    = swap_a_ff;
      p_rb    = swap_b_ff;
      q_ra    = byte_ff;

      if (csr_take) begin
         case (csr_index)
            bpsc_pkg::CSR_KEY_LOW:  key_low_in  = csr_wdata;
            bpsc_pkg::CSR_KEY_HIGH: key_high_in = csr_wdata;
            bpsc_pkg::CSR_MODE:     decrypt_in  = csr_wdata[0];
            default: ;
         endcase
      end

      case (state_ff)
         ST_IDLE: begin
            // lookup reads go out on the accept edge
            p_ra = req_data_byte;
            q_ra = req_data_byte;
            if (req_take) begin
               is_data_in = (req_command == bpsc_pkg::CMD_DATA);
               byte_in    = req_data_byte;
               idx_in     = '0;
               state_in   = ST_GEN_HI;
               if (req_command == bpsc_pkg::CMD_START) begin
                  gen_lo_in = key_low_ff;
                  gen_hi_in = key_high_ff;
                  state_in  = ST_CLEAR;
               end
            end
         end
         ST_INIT, ST_CLEAR: begin
            // one identity entry per cycle in both tables
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = idx_ff;
            tbl_ctl.wr_data = idx_ff;
            if (idx_ff == BW'(bpsc_pkg::TBL_DEPTH - 1)) begin
               idx_in   = '0;
               state_in = (state_ff == ST_INIT) ? ST_IDLE : ST_GEN_HI;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_GEN_HI: begin
            gen_hi_in = sub_diff;
            plain_in  = decrypt_ff ? p_rd_a : byte_ff;
            result_in = decrypt_ff ? p_rd_a : q_rd;
            state_in  = ST_GEN_LO;
         end
         ST_GEN_LO: begin
            sub_a     = '0;
            sub_b     = gen_lo_ff;
            sub_bin   = 1'b0;
            gen_lo_in = sub_diff;
            p_ra      = swap_a_sel;
            p_rb      = key_idx;
            swap_a_in = swap_a_sel;
            swap_b_in = key_idx;
            state_in  = ST_WR_A;
         end
         ST_WR_A: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = swap_a_ff;
            tbl_ctl.wr_data = p_rd_b;
            swap_ta_in      = p_rd_a;
            state_in        = ST_WR_B;
         end
         ST_WR_B: begin
            tbl_ctl.wr_en   = 1'b1;
            tbl_ctl.wr_addr = swap_b_ff;
            tbl_ctl.wr_data = swap_ta_ff;
            if (is_data_ff) begin
               state_in = ST_FINISH;
            end else if (idx_ff == BW'(bpsc_pkg::TBL_DEPTH - 1)) begin
               state_in = ST_IDLE;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_GEN_HI;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_byte_in  = result_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         rsp_valid_ff <= 1'b0;
         gen_lo_ff    <= '0;
         gen_hi_ff    <= '0;
         key_low_ff   <= '0;
         key_high_ff  <= '0;
         decrypt_ff   <= 1'b0;
         is_data_ff   <= 1'b0;
         idx_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         gen_lo_ff    <= gen_lo_in;
         gen_hi_ff    <= gen_hi_in;
         key_low_ff   <= key_low_in;
         key_high_ff  <= key_high_in;
         decrypt_ff   <= decrypt_in;
         is_data_ff   <= is_data_in;
         idx_ff       <= idx_in;
      end
      byte_ff     <= byte_in;
      plain_ff    <= plain_in;
      result_ff   <= result_in;
      swap_a_ff   <= swap_a_in;
      swap_b_ff   <= swap_b_in;
      swap_ta_ff  <= swap_ta_in;
      rsp_byte_ff <= rsp_byte_in;
   end

   // a start item loads the generator from the key registers
   a_start_loads_key: assert property (@(posedge clock) disable iff (reset)
      (req_take && req_command == bpsc_pkg::CMD_START) |=>
         (gen_lo_ff == $past(key_low_ff) && gen_hi_ff == $past(key_high_ff)))
      else $error("generator not loaded from key on start");

   // the second half of a swap always follows the first
   a_swap_pairs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_A) |=> (state_ff == ST_WR_B))
      else $error("swap write sequence broken");

   // a pending result is never overwritten
   a_result_waits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FINISH && rsp_valid_ff && rsp_stall) |=>
         (state_ff == ST_FINISH && $stable(rsp_byte_ff)))
      else $error("result overwritten while output stalled");

   // start items never produce a result
   a_start_silent: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR_B && !is_data_ff) |=> (state_ff != ST_FINISH))
      else $error("start item reached result stage");

endmodule
